@@ src/bba_pkg.sv @@
// Shared constants, command codes and status types of the buddy allocator.
package bba_pkg;

	localparam int MIN_ORDER    = 6;
	localparam int MAX_ORDER    = 16;
	localparam int HEADER_BYTES = 24;
	localparam int POOL_RESET   = 16;

	localparam int DEPTH_W = MAX_ORDER - MIN_ORDER;
	localparam int DEPTH   = 1 << DEPTH_W;
	localparam int LINK_W  = DEPTH_W + 1;
	localparam int NORD    = MAX_ORDER + 1;
	localparam int ORD_W   = 5;
	localparam int OFF_W   = 17;
	localparam int ST_W    = 2;
	localparam int TAGO_W  = ORD_W + 1;
	localparam int ADDR_W  = 3;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(DEPTH);
	localparam logic [ADDR_W-1:0] ADDR_POOL_ORDER = ADDR_W'(0);

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_ZERO   = 2'd1;
	localparam logic [ST_W-1:0] ST_BIG    = 2'd2;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_INIT,
		CMD_LOAD,
		CMD_A_CHECK,
		CMD_SEARCH,
		CMD_UNL_RD,
		CMD_UNL_WR,
		CMD_SPLIT,
		CMD_PUSH_A,
		CMD_PUSH_B,
		CMD_A_DONE,
		CMD_F_RD,
		CMD_F_VAL,
		CMD_M_RD,
		CMD_M_UPD,
		CMD_SETX,
		CMD_F_DONE,
		CMD_ERR_ZERO,
		CMD_ERR_BIG,
		CMD_ERR_NOFREE
	} bba_cmd_t;

	typedef struct packed {
		logic act_free;
		logic zero;
		logic big;
		logic head_nil;
		logic k_top;
		logic k_gt_ord;
		logic f_bad_pre;
		logic f_bad_val;
		logic m_stop;
		logic clr_last;
	} bba_stat_t;

endpackage

@@ src/bba_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface bba_in_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [bba_pkg::OFF_W-1:0] request_bytes;
	logic [bba_pkg::OFF_W-1:0] free_offset;

	modport source(output valid, action, request_bytes, free_offset, input ready);
	modport sink(input valid, action, request_bytes, free_offset, output ready);
endinterface

interface bba_out_if;
	logic                      valid;
	logic                      ready;
	logic [bba_pkg::ST_W-1:0]  status;
	logic [bba_pkg::OFF_W-1:0] user_offset;
	logic [bba_pkg::ORD_W-1:0] block_order;

	modport source(output valid, status, user_offset, block_order, input ready);
	modport sink(input valid, status, user_offset, block_order, output ready);
endinterface

@@ src/buddy_block_allocator_core.sv @@
// Binary buddy allocator over a pool of 2^pool_order bytes in 64-byte granules. One request
// is handled at a time; its result sits in an output register so the next request can be
// taken while it waits. An allocate searches upward one order per step past empty lists,
// then splits the block one level at a time; a free merges with its buddy one level at a
// time until merging stops. A zero or oversized allocate and a rejected free are answered
// without changing the free lists; an allocate with no free block searches each order.
// The walk takes one order per step with a registered read of the block table and links;
// an untaken result stalls the next request in its final state until the result is taken.
// After reset and after every pool_order write made while idle the block table is cleared,
// one granule a cycle, during which no request is taken.
module buddy_block_allocator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	bba_in_if.sink                             in_ch,
	bba_out_if.source                          out_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bba_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	bba_pkg::bba_stat_t        stat;
	bba_pkg::bba_cmd_t         cmd;
	logic                      cfg_we;
	logic [bba_pkg::ORD_W-1:0] po;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == bba_pkg::ADDR_POOL_ORDER[2]);
	assign prdata = 32'(po);

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	bba_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_we(cfg_we),
		.cfg_data(pwdata[bba_pkg::ORD_W-1:0]),
		.in_action(in_ch.action), .in_bytes(in_ch.request_bytes),
		.in_offset(in_ch.free_offset), .stat(stat), .pool_order(po),
		.res_status(out_ch.status), .res_offset(out_ch.user_offset),
		.res_order(out_ch.block_order)
	);
endmodule

@@ src/bba_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bba_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ src/bba_ctrl.sv @@
// Sequencer of the buddy allocator: steps the datapath through each request.
module bba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bba_pkg::bba_stat_t stat,
	output bba_pkg::bba_cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_CLEAR, S_INIT, S_INITP, S_IDLE, S_DISP, S_ACHK, S_SRCH, S_AUR, S_AUW,
		S_SPL, S_SPA, S_SPB, S_ADONE, S_FRD, S_FVAL, S_MRD, S_MCHK, S_MUR,
		S_MUW, S_MUPD, S_FPA, S_FPB, S_FDONE, S_E1, S_E2, S_E3
	} state_t;

	state_t state_q, nxt;
	logic   ov_q;
	logic   out_free;
	logic   done;

	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready  = (state_q == S_IDLE) && !cfg_we;

	always_comb begin
		nxt = state_q;
		cmd = bba_pkg::CMD_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd = bba_pkg::CMD_CLEAR;
				if (stat.clr_last) nxt = S_INIT;
			end
			S_INIT: begin
				cmd = bba_pkg::CMD_INIT;
				nxt = S_INITP;
			end
			S_INITP: begin
				cmd = bba_pkg::CMD_PUSH_A;
				nxt = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_we) begin
					nxt = S_CLEAR;
				end else if (in_valid) begin
					cmd = bba_pkg::CMD_LOAD;
					nxt = S_DISP;
				end
			end
			S_DISP: nxt = stat.act_free ? S_FRD : S_ACHK;
			S_ACHK: begin
				if (stat.zero) begin
					nxt = S_E1;
				end else if (stat.big) begin
					nxt = S_E2;
				end else begin
					cmd = bba_pkg::CMD_A_CHECK;
					nxt = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd = bba_pkg::CMD_SEARCH;
				if (!stat.head_nil) nxt = S_AUR;
				else if (stat.k_top) nxt = S_E3;
			end
			S_AUR: begin
				cmd = bba_pkg::CMD_UNL_RD;
				nxt = S_AUW;
			end
			S_AUW: begin
				cmd = bba_pkg::CMD_UNL_WR;
				nxt = S_SPL;
			end
			S_SPL: begin
				if (stat.k_gt_ord) begin
					cmd = bba_pkg::CMD_SPLIT;
					nxt = S_SPA;
				end else begin
					nxt = S_ADONE;
				end
			end
			S_SPA: begin
				cmd = bba_pkg::CMD_PUSH_A;
				nxt = S_SPB;
			end
			S_SPB: begin
				cmd = bba_pkg::CMD_PUSH_B;
				nxt = S_SPL;
			end
			S_ADONE: begin
				if (out_free) begin
					cmd = bba_pkg::CMD_A_DONE;
					nxt = S_IDLE;
				end
			end
			S_FRD: begin
				if (stat.f_bad_pre) begin
					nxt = S_E3;
				end else begin
					cmd = bba_pkg::CMD_F_RD;
					nxt = S_FVAL;
				end
			end
			S_FVAL: begin
				if (stat.f_bad_val) begin
					nxt = S_E3;
				end else begin
					cmd = bba_pkg::CMD_F_VAL;
					nxt = S_MRD;
				end
			end
			S_MRD: begin
				if (stat.k_top) begin
					cmd = bba_pkg::CMD_SETX;
					nxt = S_FPA;
				end else begin
					cmd = bba_pkg::CMD_M_RD;
					nxt = S_MCHK;
				end
			end
			S_MCHK: begin
				if (stat.m_stop) begin
					cmd = bba_pkg::CMD_SETX;
					nxt = S_FPA;
				end else begin
					nxt = S_MUR;
				end
			end
			S_MUR: begin
				cmd = bba_pkg::CMD_UNL_RD;
				nxt = S_MUW;
			end
			S_MUW: begin
				cmd = bba_pkg::CMD_UNL_WR;
				nxt = S_MUPD;
			end
			S_MUPD: begin
				cmd = bba_pkg::CMD_M_UPD;
				nxt = S_MRD;
			end
			S_FPA: begin
				cmd = bba_pkg::CMD_PUSH_A;
				nxt = S_FPB;
			end
			S_FPB: begin
				cmd = bba_pkg::CMD_PUSH_B;
				nxt = S_FDONE;
			end
			S_FDONE: begin
				if (out_free) begin
					cmd = bba_pkg::CMD_F_DONE;
					nxt = S_IDLE;
				end
			end
			S_E1: begin
				if (out_free) begin
					cmd = bba_pkg::CMD_ERR_ZERO;
					nxt = S_IDLE;
				end
			end
			S_E2: begin
				if (out_free) begin
					cmd = bba_pkg::CMD_ERR_BIG;
					nxt = S_IDLE;
				end
			end
			S_E3: begin
				if (out_free) begin
					cmd = bba_pkg::CMD_ERR_NOFREE;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_CLEAR;
		endcase
	end

	assign done = (cmd == bba_pkg::CMD_A_DONE) || (cmd == bba_pkg::CMD_F_DONE) ||
		(cmd == bba_pkg::CMD_ERR_ZERO) || (cmd == bba_pkg::CMD_ERR_BIG) ||
		(cmd == bba_pkg::CMD_ERR_NOFREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= nxt;
			if (done) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

@@ src/bba_dp.sv @@
// Datapath of the buddy allocator: block table, free-list links and list heads.
module bba_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bba_pkg::bba_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [bba_pkg::ORD_W-1:0]           cfg_data,
	input  logic                                in_action,
	input  logic [bba_pkg::OFF_W-1:0]           in_bytes,
	input  logic [bba_pkg::OFF_W-1:0]           in_offset,
	output bba_pkg::bba_stat_t                  stat,
	output logic [bba_pkg::ORD_W-1:0]           pool_order,
	output logic [bba_pkg::ST_W-1:0]            res_status,
	output logic [bba_pkg::OFF_W-1:0]           res_offset,
	output logic [bba_pkg::ORD_W-1:0]           res_order
);
	localparam int GW = bba_pkg::DEPTH_W;
	localparam int LW = bba_pkg::LINK_W;
	localparam int OW = bba_pkg::ORD_W;
	localparam int FW = bba_pkg::OFF_W;
	localparam int NW = FW + 1;
	localparam int MN = bba_pkg::MIN_ORDER;

	function automatic logic [OW-1:0] ceil_log2(input logic [NW-1:0] v);
		logic [NW-1:0] m;
		logic [OW-1:0] r;
		m = v - NW'(1);
		r = '0;
		for (int i = 0; i < NW; i++) begin
			if (m[i]) r = OW'(i + 1);
		end
		return r;
	endfunction

	logic [OW-1:0] po_q, order_q, k_q, res_ord_q;
	logic          action_q;
	logic [FW-1:0] bytes_q, off_q, res_off_q;
	logic [GW-1:0] g_q, x_q, cnt_q;
	logic [LW-1:0] h_q;
	logic [LW-1:0] head_q [bba_pkg::NORD];
	logic [bba_pkg::ST_W-1:0] res_st_q;

	logic [NW-1:0] need;
	logic [OW-1:0] ord_need, ord_cl, cfg_cl;
	logic [LW-1:0] head_k;
	logic [FW-1:0] blk;
	logic [GW-1:0] bud, split_b;
	logic [OW-1:0] sh;

	logic                       to_we;
	logic [GW-1:0]              to_wa, to_ra;
	logic [bba_pkg::TAGO_W-1:0] to_wd, to_rd;
	logic                       nx_we, pv_we;
	logic [GW-1:0]              nx_wa, pv_wa;
	logic [LW-1:0]              nx_wd, pv_wd, nx_rd, pv_rd;

	assign need     = NW'(bytes_q) + NW'(bba_pkg::HEADER_BYTES);
	assign ord_need = ceil_log2(need);
	assign ord_cl   = (ord_need < OW'(MN)) ? OW'(MN) : ord_need;
	assign head_k   = head_q[k_q];
	assign blk      = off_q - FW'(bba_pkg::HEADER_BYTES);
	assign sh       = k_q - OW'(MN);
	assign bud      = g_q ^ (GW'(1) << sh);
	assign split_b  = g_q + (GW'(1) << (sh - OW'(1)));
	assign cfg_cl   = (cfg_data < OW'(MN)) ? OW'(MN) :
		(cfg_data > OW'(bba_pkg::MAX_ORDER)) ? OW'(bba_pkg::MAX_ORDER) : cfg_data;

	assign stat.act_free  = action_q;
	assign stat.zero      = (bytes_q == '0);
	assign stat.big       = (ord_need > po_q);
	assign stat.head_nil  = (head_k == bba_pkg::NIL);
	assign stat.k_top     = (k_q >= po_q);
	assign stat.k_gt_ord  = (k_q > order_q);
	assign stat.f_bad_pre = (off_q < FW'(bba_pkg::HEADER_BYTES)) || (blk[MN-1:0] != '0) ||
		((blk >> po_q) != '0);
	assign stat.f_bad_val = (to_rd[OW-1:0] == '0) || to_rd[OW] ||
		(to_rd[OW-1:0] < OW'(MN)) || (to_rd[OW-1:0] > po_q);
	assign stat.m_stop    = !to_rd[OW] || (to_rd[OW-1:0] != k_q);
	assign stat.clr_last  = (cnt_q == '1);

	always_comb begin
		to_we = 1'b0;
		to_wa = cnt_q;
		to_wd = '0;
		to_ra = g_q;
		nx_we = 1'b0;
		nx_wa = x_q;
		nx_wd = head_k;
		pv_we = 1'b0;
		pv_wa = x_q;
		pv_wd = bba_pkg::NIL;
		case (cmd)
			bba_pkg::CMD_CLEAR: to_we = 1'b1;
			bba_pkg::CMD_UNL_WR: begin
				nx_we = (pv_rd != bba_pkg::NIL);
				nx_wa = pv_rd[GW-1:0];
				nx_wd = nx_rd;
				pv_we = (nx_rd != bba_pkg::NIL);
				pv_wa = nx_rd[GW-1:0];
				pv_wd = pv_rd;
			end
			bba_pkg::CMD_PUSH_A: begin
				to_we = 1'b1;
				to_wa = x_q;
				to_wd = {1'b1, k_q};
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			bba_pkg::CMD_PUSH_B: begin
				pv_we = (h_q != bba_pkg::NIL);
				pv_wa = h_q[GW-1:0];
				pv_wd = {1'b0, x_q};
			end
			bba_pkg::CMD_A_DONE: begin
				to_we = 1'b1;
				to_wa = g_q;
				to_wd = {1'b0, order_q};
			end
			bba_pkg::CMD_F_RD: to_ra = blk[GW+MN-1:MN];
			bba_pkg::CMD_M_RD: to_ra = bud;
			bba_pkg::CMD_M_UPD: begin
				to_we = 1'b1;
				to_wa = (x_q > g_q) ? x_q : g_q;
			end
			default: ;
		endcase
	end

	bba_ram #(.W(bba_pkg::TAGO_W), .D(bba_pkg::DEPTH)) u_tago (
		.clk(clk), .we(to_we), .waddr(to_wa), .wdata(to_wd), .raddr(to_ra), .rdata(to_rd)
	);
	bba_ram #(.W(LW), .D(bba_pkg::DEPTH)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(x_q), .rdata(nx_rd)
	);
	bba_ram #(.W(LW), .D(bba_pkg::DEPTH)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(x_q), .rdata(pv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			po_q  <= OW'(bba_pkg::POOL_RESET);
			cnt_q <= '0;
			for (int i = 0; i < bba_pkg::NORD; i++) head_q[i] <= bba_pkg::NIL;
		end else begin
			if (cfg_we) po_q <= cfg_cl;
			case (cmd)
				bba_pkg::CMD_CLEAR: begin
					cnt_q <= cnt_q + GW'(1);
					for (int i = 0; i < bba_pkg::NORD; i++) head_q[i] <= bba_pkg::NIL;
				end
				bba_pkg::CMD_UNL_WR: begin
					if (pv_rd == bba_pkg::NIL) head_q[k_q] <= nx_rd;
				end
				bba_pkg::CMD_PUSH_A: head_q[k_q] <= {1'b0, x_q};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			bba_pkg::CMD_INIT: begin
				x_q <= '0;
				k_q <= po_q;
			end
			bba_pkg::CMD_LOAD: begin
				action_q <= in_action;
				bytes_q  <= in_bytes;
				off_q    <= in_offset;
			end
			bba_pkg::CMD_A_CHECK: begin
				order_q <= ord_cl;
				k_q     <= ord_cl;
			end
			bba_pkg::CMD_SEARCH: begin
				if (head_k == bba_pkg::NIL) begin
					k_q <= k_q + OW'(1);
				end else begin
					g_q <= head_k[GW-1:0];
					x_q <= head_k[GW-1:0];
				end
			end
			bba_pkg::CMD_SPLIT: begin
				k_q <= k_q - OW'(1);
				x_q <= split_b;
			end
			bba_pkg::CMD_PUSH_A: h_q <= head_k;
			bba_pkg::CMD_F_RD: g_q <= blk[GW+MN-1:MN];
			bba_pkg::CMD_F_VAL: k_q <= to_rd[OW-1:0];
			bba_pkg::CMD_M_RD: x_q <= bud;
			bba_pkg::CMD_M_UPD: begin
				g_q <= (x_q < g_q) ? x_q : g_q;
				k_q <= k_q + OW'(1);
			end
			bba_pkg::CMD_SETX: x_q <= g_q;
			bba_pkg::CMD_A_DONE: begin
				res_st_q  <= bba_pkg::ST_OK;
				res_off_q <= FW'({g_q, MN'(0)}) + FW'(bba_pkg::HEADER_BYTES);
				res_ord_q <= order_q;
			end
			bba_pkg::CMD_F_DONE: begin
				res_st_q  <= bba_pkg::ST_OK;
				res_off_q <= FW'({g_q, MN'(0)});
				res_ord_q <= k_q;
			end
			bba_pkg::CMD_ERR_ZERO: begin
				res_st_q  <= bba_pkg::ST_ZERO;
				res_off_q <= '0;
				res_ord_q <= '0;
			end
			bba_pkg::CMD_ERR_BIG: begin
				res_st_q  <= bba_pkg::ST_BIG;
				res_off_q <= '0;
				res_ord_q <= '0;
			end
			bba_pkg::CMD_ERR_NOFREE: begin
				res_st_q  <= bba_pkg::ST_NOFREE;
				res_off_q <= '0;
				res_ord_q <= '0;
			end
			default: ;
		endcase
	end

	assign pool_order = po_q;
	assign res_status = res_st_q;
	assign res_offset = res_off_q;
	assign res_order  = res_ord_q;
endmodule

@@ src/bba_chk.sv @@
// Port-level checks on result beats of the buddy allocator, bound to the top level.
module bba_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bba_pkg::ST_W-1:0]  status,
	input logic [bba_pkg::OFF_W-1:0] user_offset,
	input logic [bba_pkg::ORD_W-1:0] block_order
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(user_offset) &&
		$stable(block_order))
		else $error("stalled result beat changed");

	a_ok_ord: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bba_pkg::ST_OK |->
		block_order >= bba_pkg::ORD_W'(bba_pkg::MIN_ORDER) &&
		block_order <= bba_pkg::ORD_W'(bba_pkg::MAX_ORDER))
		else $error("block order out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bba_pkg::ST_OK |-> user_offset == '0 && block_order == '0)
		else $error("failed request carries an offset");
endmodule

bind buddy_block_allocator_core bba_chk u_bba_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .user_offset(out_ch.user_offset),
	.block_order(out_ch.block_order)
);

@@ sim/tb_buddy_block_allocator_core.sv @@
// Self-checking testbench for the buddy allocator core: directed table, random traffic, predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {ACT_ALLOC = 1'b0, ACT_FREE = 1'b1} act_t;

	typedef struct packed {
		logic [bba_pkg::ST_W-1:0]  status;
		logic [bba_pkg::OFF_W-1:0] user_offset;
		logic [bba_pkg::ORD_W-1:0] block_order;
	} grant_t;

	typedef struct {
		act_t                      action;
		logic [bba_pkg::OFF_W-1:0] bytes;
		logic [bba_pkg::OFF_W-1:0] offset;
		bit                        known;
		grant_t                    grant;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [bba_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bba_in_if  req_ch();
	bba_out_if rsp_ch();

	buddy_block_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(req_ch.sink), .out_ch(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = 1'b0;
		req_ch.request_bytes = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
	end

	// predictor state
	int unsigned pool_ord;
	bit          tag_mem [bba_pkg::DEPTH];
	int unsigned ord_mem [bba_pkg::DEPTH];
	int unsigned nxt_mem [bba_pkg::DEPTH];
	int unsigned prv_mem [bba_pkg::DEPTH];
	int unsigned head_q [bba_pkg::NORD];
	int unsigned tail_q [bba_pkg::NORD];

	grant_t      grants_due[$];
	int unsigned live_offs[$];
	int unsigned mismatches = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_recv = 1'b0;
	bit          offering = 1'b0;

	function automatic void fl_push(int unsigned g, int unsigned k);
		int unsigned h;
		h = head_q[k];
		prv_mem[g] = bba_pkg::DEPTH;
		nxt_mem[g] = h;
		if (h < bba_pkg::DEPTH) prv_mem[h] = g;
		else tail_q[k] = g;
		head_q[k] = g;
	endfunction

	function automatic void fl_unlink(int unsigned g, int unsigned k);
		int unsigned p, n;
		p = prv_mem[g];
		n = nxt_mem[g];
		if (p < bba_pkg::DEPTH) nxt_mem[p] = n;
		else head_q[k] = n;
		if (n < bba_pkg::DEPTH) prv_mem[n] = p;
		else tail_q[k] = p;
	endfunction

	function automatic void pool_reinit(int unsigned v);
		pool_ord = v < bba_pkg::MIN_ORDER ? bba_pkg::MIN_ORDER :
			(v > bba_pkg::MAX_ORDER ? bba_pkg::MAX_ORDER : v);
		for (int i = 0; i < bba_pkg::DEPTH; i++) begin
			tag_mem[i] = 0;
			ord_mem[i] = 0;
			nxt_mem[i] = 0;
			prv_mem[i] = 0;
		end
		for (int k = 0; k < bba_pkg::NORD; k++) begin
			head_q[k] = bba_pkg::DEPTH;
			tail_q[k] = bba_pkg::DEPTH;
		end
		tag_mem[0] = 1;
		ord_mem[0] = pool_ord;
		fl_push(0, pool_ord);
	endfunction

	function automatic grant_t buddy_step(act_t a, int unsigned bytes, int unsigned off);
		grant_t r;
		int unsigned ord, k, g, b, hi, blk;
		longint unsigned need;
		r = '0;
		if (a == ACT_ALLOC) begin
			if (bytes == 0) begin
				r.status = bba_pkg::ST_ZERO;
				return r;
			end
			need = bytes + bba_pkg::HEADER_BYTES;
			ord = 0;
			while ((64'd1 << ord) < need) ord++;
			if (ord > pool_ord) begin
				r.status = bba_pkg::ST_BIG;
				return r;
			end
			if (ord < bba_pkg::MIN_ORDER) ord = bba_pkg::MIN_ORDER;
			g = bba_pkg::DEPTH;
			for (k = ord; k <= pool_ord; k++)
				if (head_q[k] < bba_pkg::DEPTH) begin
					g = head_q[k];
					break;
				end
			if (g >= bba_pkg::DEPTH) begin
				r.status = bba_pkg::ST_NOFREE;
				return r;
			end
			fl_unlink(g, k);
			while (k > ord) begin
				k--;
				b = g + (1 << (k - bba_pkg::MIN_ORDER));
				if (b < bba_pkg::DEPTH) begin
					tag_mem[b] = 1;
					ord_mem[b] = k;
					fl_push(b, k);
				end
			end
			tag_mem[g] = 0;
			ord_mem[g] = ord;
			r.status = bba_pkg::ST_OK;
			r.user_offset = bba_pkg::OFF_W'((g << bba_pkg::MIN_ORDER) + bba_pkg::HEADER_BYTES);
			r.block_order = bba_pkg::ORD_W'(ord);
			return r;
		end
		r.status = bba_pkg::ST_NOFREE;
		if (off < bba_pkg::HEADER_BYTES) return r;
		blk = off - bba_pkg::HEADER_BYTES;
		if (blk[bba_pkg::MIN_ORDER-1:0] != 0) return r;
		blk = blk >> bba_pkg::MIN_ORDER;
		if (blk >= (1 << (pool_ord - bba_pkg::MIN_ORDER))) return r;
		g = blk;
		k = ord_mem[g];
		if (k == 0 || tag_mem[g] != 0 || k < bba_pkg::MIN_ORDER || k > pool_ord) return r;
		while (k < pool_ord) begin
			b = g ^ (1 << (k - bba_pkg::MIN_ORDER));
			if (b >= bba_pkg::DEPTH || tag_mem[b] != 1 || ord_mem[b] != k) break;
			fl_unlink(b, k);
			hi = b > g ? b : g;
			g = b < g ? b : g;
			tag_mem[hi] = 0;
			ord_mem[hi] = 0;
			k++;
		end
		tag_mem[g] = 1;
		ord_mem[g] = k;
		fl_push(g, k);
		r.status = bba_pkg::ST_OK;
		r.user_offset = bba_pkg::OFF_W'(g << bba_pkg::MIN_ORDER);
		r.block_order = bba_pkg::ORD_W'(k);
		return r;
	endfunction

	// result sink with random stalls
	always @(posedge clk) begin
		if (hold_recv) rsp_ch.ready <= 1'b0;
		else rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
		if (rsp_ch.valid && rsp_ch.ready) begin
			grant_t got, want;
			got.status = rsp_ch.status;
			got.user_offset = rsp_ch.user_offset;
			got.block_order = rsp_ch.block_order;
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", got);
			end else begin
				want = grants_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("expected %p got %p", want, got);
				end
			end
		end
	end

	task automatic idle_in();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send(act_t a, int unsigned bytes, int unsigned off, bit known = 0,
			grant_t g = '0);
		grant_t p;
		if ($urandom_range(99) < send_idle) begin
			idle_in();
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= a;
		req_ch.request_bytes <= bba_pkg::OFF_W'(bytes);
		req_ch.free_offset <= bba_pkg::OFF_W'(off);
		offering = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		p = buddy_step(a, bytes, off);
		grants_due.push_back(known ? g : p);
		if (a == ACT_ALLOC && p.status == bba_pkg::ST_OK) live_offs.push_back(p.user_offset);
		if (a == ACT_FREE && p.status == bba_pkg::ST_OK)
			foreach (live_offs[i]) if (live_offs[i] == off) begin
				live_offs.delete(i);
				break;
			end
	endtask

	task automatic drain();
		idle_in();
		while (grants_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_pool_order(int unsigned v);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= bba_pkg::ADDR_POOL_ORDER;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pool_reinit(v);
		live_offs.delete();
	endtask

	task automatic random_phase(int n);
		int unsigned o, r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				o = $urandom_range(pool_ord);
				send(ACT_ALLOC, $urandom_range(1 << o) + ($urandom_range(9) == 0 ? 0 : 1), 0);
			end else if (r < 85 && live_offs.size() != 0)
				send(ACT_FREE, 0, live_offs[$urandom_range(live_offs.size() - 1)]);
			else if (r < 92)
				send(ACT_ALLOC, $urandom_range(131071), 0);
			else
				send(ACT_FREE, 0, $urandom_range(131071));
		end
	endtask

	row_t dir_rows[$];

	initial begin
		row_t row;
		pool_reinit(bba_pkg::POOL_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		dir_rows = '{
			'{ACT_ALLOC, 0, 0, 1, '{bba_pkg::ST_ZERO, 0, 0}},
			'{ACT_ALLOC, 131071, 0, 1, '{bba_pkg::ST_BIG, 0, 0}},
			'{ACT_ALLOC, 65536, 0, 1, '{bba_pkg::ST_BIG, 0, 0}},
			'{ACT_ALLOC, 65512, 0, 1, '{bba_pkg::ST_OK, 24, 16}},
			'{ACT_ALLOC, 1, 0, 1, '{bba_pkg::ST_NOFREE, 0, 0}},
			'{ACT_FREE, 0, 24, 1, '{bba_pkg::ST_OK, 0, 16}},
			'{ACT_FREE, 0, 24, 1, '{bba_pkg::ST_NOFREE, 0, 0}},
			'{ACT_FREE, 0, 0, 1, '{bba_pkg::ST_NOFREE, 0, 0}},
			'{ACT_FREE, 0, 25, 1, '{bba_pkg::ST_NOFREE, 0, 0}},
			'{ACT_FREE, 0, 131071, 1, '{bba_pkg::ST_NOFREE, 0, 0}},
			'{ACT_ALLOC, 1, 0, 1, '{bba_pkg::ST_OK, 24, 6}},
			'{ACT_ALLOC, 40, 0, 0, '0},
			'{ACT_ALLOC, 41, 0, 0, '0},
			'{ACT_ALLOC, 1000, 0, 0, '0},
			'{ACT_FREE, 0, 88, 0, '0},
			'{ACT_FREE, 0, 24, 0, '0},
			'{ACT_FREE, 0, 152, 0, '0},
			'{ACT_ALLOC, 32767, 0, 0, '0}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send(row.action, row.bytes, row.offset, row.known, row.grant);
		end
		write_pool_order(6);
		send(ACT_ALLOC, 40, 0, 1, '{bba_pkg::ST_OK, 24, 6});
		send(ACT_ALLOC, 41, 0, 1, '{bba_pkg::ST_BIG, 0, 0});
		random_phase(60);
		write_pool_order(31);
		random_phase(100);
		write_pool_order(0);
		random_phase(60);
		write_pool_order(10);
		random_phase(500);
		send_idle = 49;
		random_phase(350);
		send_idle = 0;
		recv_stall = 49;
		random_phase(350);
		fork
			begin
				hold_recv = 1'b1;
				repeat (400) @(posedge clk);
				hold_recv = 1'b0;
			end
			begin
				random_phase(30);
				idle_in();
			end
		join
		recv_stall = 0;
		drain();
		random_phase(20);
		write_pool_order(16);
		send_idle = 15;
		recv_stall = 15;
		random_phase(500);
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
